### hdl/che_pkg.sv
// Shared types and constants for the colour histogram equaliser.
package che_pkg;

  localparam int NUM_CH   = 3;
  localparam int NUM_BINS = 256;
  localparam int PIX_W    = 8;
  localparam logic [PIX_W-1:0] PEAK_LEVEL = 8'd255;

  // operation codes
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] red_in;
    logic             last_of_pass;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] red_out;
    logic             frame_done;
  } result_t;

endpackage

### hdl/che_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module che_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/color_histogram_equalizer_core.sv
// Per-channel 8-bit histogram equaliser: counting pass, table build, mapping pass.
//
// Counting requests (operation 0) and mapping requests (operation 1) are each taken
// at one per cycle unless the input stalls. Counting is a read-modify-write on three
// 256-entry histogram banks (one per colour) with a registered read; a forwarding
// register per bank covers back-to-back hits on the same bin. A counting request
// marked last stalls the input while the tables are built: a drain step, then per bin
// a read, a load, a shift-subtract divider giving floor(255*bin count/pixel total)
// and a table write, for all three channels in parallel. A mapping request reads the
// three table banks; the read data moves into the output register as soon as that is
// free, so a result passes the table read register, then the output register; one
// more request is taken while a result waits, and the input stalls on the output only
// when both are full. A mapping request marked last is followed by a pass over all
// bins that zeroes the histograms; after reset, such a pass zeroes histograms and
// tables before the first request is taken. Counts and bins saturate at MAX_PIXELS.
module color_histogram_equalizer_core
  import che_pkg::*;
#(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    pixel_valid,
  output logic    pixel_stall,
  input  pixel_t  pixel,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int NUM_W = CNT_W + PIX_W;
  localparam int AW    = $clog2(NUM_BINS);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PIXELS);
  localparam logic [AW-1:0]    LAST_BIN = AW'(NUM_BINS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_RUN, S_DRAIN, S_RD, S_LOAD, S_DIV, S_WR
  } state_t;

  state_t state;
  logic [AW-1:0]    idx;
  logic             clr_tables;
  logic [2:0]       step;
  logic [CNT_W-1:0] pixel_total;
  logic [NUM_W-1:0] dsh;
  logic             frame_done;
  logic             pend;   // table read data not yet in the output register
  logic             move;

  logic accept, count_acc, map_acc;
  logic [PIX_W-1:0] chan_val [NUM_CH];

  assign chan_val[0] = pixel.blue_in;
  assign chan_val[1] = pixel.green_in;
  assign chan_val[2] = pixel.red_in;

  assign move        = pend && (!result_valid || !result_stall);
  assign pixel_stall = (state != S_RUN) || (pend && result_valid && result_stall);
  assign accept      = pixel_valid && !pixel_stall;
  assign count_acc   = accept && (pixel.operation == OP_COUNT);
  assign map_acc     = accept && (pixel.operation == OP_MAP);

  // second stage of the counting read-modify-write
  logic          s2_valid;
  logic [AW-1:0] s2_addr [NUM_CH];

  logic [PIX_W-1:0] tab_out [NUM_CH];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [CNT_W-1:0] hist_rd, hist_cur, hist_new, hist_wd;
    logic [AW-1:0]    hist_wa, hist_ra;
    logic             hist_we, hist_re;
    logic [AW-1:0]    hold_addr;
    logic [CNT_W-1:0] hold_data;
    logic             hold_vld;
    logic [NUM_W-1:0] rem;
    logic [PIX_W-1:0] quo, prev, tab_val;
    logic [PIX_W:0]   sum;
    logic             tab_we;
    logic [PIX_W-1:0] tab_wd;

    // newest write forwarded over the stale read
    assign hist_cur = (hold_vld && hold_addr == s2_addr[c]) ? hold_data : hist_rd;
    assign hist_new = (hist_cur >= CNT_MAX) ? CNT_MAX : hist_cur + CNT_W'(1);

    always_comb begin
      if (state == S_CLEAR) begin
        hist_we = 1'b1;
        hist_wa = idx;
        hist_wd = '0;
      end else begin
        hist_we = s2_valid;
        hist_wa = s2_addr[c];
        hist_wd = hist_new;
      end
    end

    assign hist_re = count_acc || (state == S_RD);
    assign hist_ra = (state == S_RD) ? idx : chan_val[c];

    che_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_hist (
      .clk(clk), .we(hist_we), .waddr(hist_wa), .wdata(hist_wd),
      .re(hist_re), .raddr(hist_ra), .rdata(hist_rd)
    );

    // running sum, saturating at peak; zero count gives zero entries
    assign sum     = {1'b0, (pixel_total == '0) ? '0 : quo} + {1'b0, prev};
    assign tab_val = (sum > {1'b0, PEAK_LEVEL}) ? PEAK_LEVEL : sum[PIX_W-1:0];
    assign tab_we  = (state == S_WR) || (state == S_CLEAR && clr_tables);
    assign tab_wd  = (state == S_WR) ? tab_val : '0;

    che_ram #(.WIDTH(PIX_W), .DEPTH(NUM_BINS)) u_tab (
      .clk(clk), .we(tab_we), .waddr(idx), .wdata(tab_wd),
      .re(map_acc), .raddr(chan_val[c]), .rdata(tab_out[c])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        hold_vld <= 1'b0;
      end else if (state == S_CLEAR) begin
        hold_vld <= 1'b0;
      end else if (s2_valid) begin
        hold_vld <= 1'b1;
      end
      if (s2_valid) begin
        hold_addr <= s2_addr[c];
        hold_data <= hist_new;
      end
      if (count_acc) begin
        s2_addr[c] <= chan_val[c];
      end
      case (state)
        S_DRAIN: prev <= '0;
        S_LOAD: begin
          rem <= {hist_rd, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, hist_rd};
          quo <= '0;
        end
        S_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[PIX_W-2:0], 1'b1};
          end else begin
            quo <= {quo[PIX_W-2:0], 1'b0};
          end
        end
        S_WR: prev <= tab_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      idx          <= '0;
      clr_tables   <= 1'b1;
      step         <= '0;
      pixel_total  <= '0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      result       <= '0;
      frame_done   <= 1'b0;
      pend         <= 1'b0;
    end else begin
      s2_valid <= count_acc;
      if (map_acc) begin
        frame_done <= pixel.last_of_pass;
      end
      pend <= map_acc || (pend && !move);
      // output register takes the table read data once it is free
      if (move) begin
        result_valid         <= 1'b1;
        result.blue_out      <= tab_out[0];
        result.green_out     <= tab_out[1];
        result.red_out       <= tab_out[2];
        result.frame_done    <= frame_done;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + AW'(1);
          if (idx == LAST_BIN) begin
            state      <= S_RUN;
            clr_tables <= 1'b0;
          end
        end
        S_RUN: begin
          if (count_acc) begin
            pixel_total <= (pixel_total >= CNT_MAX) ? CNT_MAX : pixel_total + CNT_W'(1);
            if (pixel.last_of_pass) begin
              state <= S_DRAIN;
            end
          end else if (map_acc && pixel.last_of_pass) begin
            pixel_total <= '0;
            state       <= S_CLEAR;
            idx         <= '0;
          end
        end
        S_DRAIN: begin
          idx   <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          dsh   <= {1'b0, pixel_total, {(PIX_W-1){1'b0}}};
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dsh  <= dsh >> 1;
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          idx <= idx + AW'(1);
          state <= (idx == LAST_BIN) ? S_RUN : S_RD;
        end
        default: state <= S_RUN;
      endcase
    end
  end

  a_total_sat: assert property (@(posedge clk) disable iff (rst)
    pixel_total <= CNT_MAX) else $error("pixel total above saturation");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    map_acc && pixel.last_of_pass |=> pixel_stall && state == S_CLEAR)
    else $error("no clearing pass after last mapped pixel");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pend)) else $error("result without mapping request");

  a_build_after_last: assert property (@(posedge clk) disable iff (rst)
    count_acc && pixel.last_of_pass |=> state == S_DRAIN)
    else $error("table build not started");

endmodule
